### rtl/assert_macros.svh
// Assertion macros for the replacement engine, used by the eaf_ctrl module.
// Depends on nothing; SYNTH selects the empty forms for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define EAF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define EAF_ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define EAF_ASSERT(label, clk, rst, prop, msg)
`define EAF_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

### rtl/eaf_pkg.sv
// Types, constants and helper functions for the replacement engine.
// Used by the controller, the datapath and the top level.
package eaf_pkg;

  localparam int SETS      = 1024;
  localparam int SET_W     = 10;
  localparam int WAYS      = 16;
  localparam int WAY_W     = 4;
  localparam int RANK_W    = 4;
  localparam int ADDR_W    = 58;
  localparam int LANES     = 16;
  localparam int LANE_W    = 4;
  localparam int LFSR_W    = 16;
  localparam logic [LFSR_W-1:0] SEED_RESET = 16'd44257;
  localparam logic [2:0] REG_RANDOM_SEED = 3'd0;

  typedef logic [WAYS-1:0][RANK_W-1:0] rank_row_t;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic lru_rd;
    logic push;
    logic scan_rd;
    logic eval;
    logic load_out;
  } eaf_cmd_t;

  typedef struct packed {
    logic mode;
    logic hit;
    logic clear_last;
    logic scan_last;
  } eaf_status_t;

  function automatic rank_row_t init_row();
    rank_row_t r;
    for (int i = 0; i < WAYS; i++) begin
      r[i] = RANK_W'(i);
    end
    return r;
  endfunction

endpackage

### rtl/eaf_ctrl.sv
// Sequencing state machine of the replacement engine.
// Depends on eaf_pkg and assert_macros.svh; drives the datapath by commands.
`include "assert_macros.svh"
module eaf_ctrl import eaf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  eaf_status_t status,
  output eaf_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_CLEAR    = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_READ     = 7'b0000100,
    S_SCAN     = 7'b0001000,
    S_SCAN_END = 7'b0010000,
    S_EVAL     = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.lru_rd = 1'b1;
        if (status.mode && !status.hit) begin
          cmd.push = 1'b1;
          state_next = S_SCAN;
        end else begin
          state_next = S_EVAL;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.scan_last) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_stall = (state != S_IDLE);

  `EAF_ASSERT(a_rise_after_done, clk, rst, $rose(out_valid) |-> $past(state == S_DONE), "result shown without evaluation")
  `EAF_ASSERT(a_accept_reads, clk, rst, (in_valid && !in_stall) |=> (state == S_READ), "accepted item not read")
  `EAF_ASSERT_NEVER(a_no_accept_in_clear, clk, rst, (state == S_CLEAR) && cmd.accept, "item accepted during rank clearing")

endmodule

### rtl/eaf_datapath.sv
// Rank memory, evicted address filter memory, LFSR and result registers.
// Depends on eaf_pkg; steered by the eaf_ctrl commands.
module eaf_datapath import eaf_pkg::*; #(
  parameter int FILTER_DEPTH = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  eaf_cmd_t           cmd,
  output eaf_status_t        status,
  input  logic               cfg_wr,
  input  logic [LFSR_W-1:0]  cfg_data,
  output logic [LFSR_W-1:0]  seed,
  input  logic               mode,
  input  logic [SET_W-1:0]   set_index,
  input  logic [WAY_W-1:0]   way_index,
  input  logic               was_hit,
  input  logic [ADDR_W-1:0]  block_address,
  input  logic [ADDR_W-1:0]  victim_address,
  output logic [WAY_W-1:0]   victim_way,
  output logic               filter_match,
  output logic               promoted
);

  localparam int ROWS    = (FILTER_DEPTH + LANES - 1) / LANES;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ENTRY_W = ROW_W + LANE_W;
  localparam int CNT_W   = ENTRY_W + 1;

  logic               mode_q;
  logic [SET_W-1:0]   set_q;
  logic [WAY_W-1:0]   way_q;
  logic               hit_q;
  logic [ADDR_W-1:0]  baddr_q;
  logic [ADDR_W-1:0]  vaddr_q;

  rank_row_t          lru_mem [SETS];
  rank_row_t          lru_row;
  rank_row_t          new_row;
  logic [SET_W-1:0]   clr_cnt;

  logic [ADDR_W-1:0]  fmem [ROWS][LANES];
  logic [ADDR_W-1:0]  frow [LANES];
  logic [ENTRY_W-1:0] wr_ptr;
  logic [CNT_W-1:0]   fill_count;
  logic [ROW_W-1:0]   scan_row;
  logic [ROW_W-1:0]   scan_row_q;
  logic               scan_valid;
  logic               match_q;
  logic               row_hit;

  logic [LFSR_W-1:0]  lfsr;
  logic [LFSR_W-1:0]  lfsr_next;
  logic               doit;
  logic [WAY_W-1:0]   best_way;
  logic [RANK_W-1:0]  old_rank;

  logic [WAY_W-1:0]   res_way;
  logic               res_match;
  logic               res_prom;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_q  <= mode;
      set_q   <= set_index;
      way_q   <= way_index;
      hit_q   <= was_hit;
      baddr_q <= block_address;
      vaddr_q <= victim_address;
    end
  end

  assign status.mode       = mode_q;
  assign status.hit        = hit_q;
  assign status.clear_last = (clr_cnt == SET_W'(SETS - 1));
  assign status.scan_last  = (scan_row == ROW_W'(ROWS - 1));

  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      lru_mem[clr_cnt] <= init_row();
    end else if (cmd.eval && mode_q && doit) begin
      lru_mem[set_q] <= new_row;
    end
    if (cmd.lru_rd) begin
      lru_row <= lru_mem[set_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_wr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_comb begin
    old_rank = lru_row[way_q];
    for (int i = 0; i < WAYS; i++) begin
      if (lru_row[i] < old_rank) begin
        new_row[i] = lru_row[i] + 1'b1;
      end else begin
        new_row[i] = lru_row[i];
      end
    end
    new_row[way_q] = '0;
  end

  // Ranks in a set always form a permutation, so the victim holds the top rank.
  always_comb begin
    best_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (lru_row[i] == RANK_W'(WAYS - 1)) begin
        best_way = WAY_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      fmem[ROW_W'(wr_ptr >> LANE_W)][LANE_W'(wr_ptr)] <= vaddr_q;
    end
    if (cmd.scan_rd) begin
      frow <= fmem[scan_row];
    end
    scan_row_q <= scan_row;
  end

  always_comb begin
    row_hit = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      if ((CNT_W'({scan_row_q, LANE_W'(l)}) < fill_count) && (frow[l] == baddr_q)) begin
        row_hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      fill_count <= '0;
      scan_row   <= '0;
      scan_valid <= 1'b0;
      match_q    <= 1'b0;
    end else begin
      scan_valid <= cmd.scan_rd;
      if (cmd.push) begin
        if (wr_ptr == ENTRY_W'(FILTER_DEPTH - 1)) begin
          wr_ptr <= '0;
        end else begin
          wr_ptr <= wr_ptr + 1'b1;
        end
        if (fill_count != CNT_W'(FILTER_DEPTH)) begin
          fill_count <= fill_count + 1'b1;
        end
      end
      if (cmd.accept) begin
        scan_row <= '0;
        match_q  <= 1'b0;
      end else begin
        if (cmd.scan_rd) begin
          scan_row <= scan_row + 1'b1;
        end
        if (scan_valid && row_hit) begin
          match_q <= 1'b1;
        end
      end
    end
  end

  assign lfsr_next = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[LFSR_W-1:1]};
  assign doit      = hit_q || match_q || (lfsr_next[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
      lfsr <= SEED_RESET;
    end else if (cfg_wr) begin
      seed <= (cfg_data == '0) ? SEED_RESET : cfg_data;
      lfsr <= (cfg_data == '0) ? SEED_RESET : cfg_data;
    end else if (cmd.eval && mode_q && !hit_q && !match_q) begin
      lfsr <= lfsr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      if (mode_q) begin
        res_way   <= '0;
        res_match <= match_q && !hit_q;
        res_prom  <= doit;
      end else begin
        res_way   <= best_way;
        res_match <= 1'b0;
        res_prom  <= 1'b0;
      end
    end
    if (cmd.load_out) begin
      victim_way   <= res_way;
      filter_match <= res_match;
      promoted     <= res_prom;
    end
  end

endmodule

### rtl/eaf_lru_replacement.sv
// Top level of the evicted address filter replacement engine.
// Depends on eaf_pkg, eaf_ctrl and eaf_datapath.
//
// After reset the rank memory is initialised one set per cycle; no item is taken until all sets
// are done. One item is handled at a time: a query or a hit passes through the read, evaluate and
// done states, and the next item is taken only after its result is loaded for output. A miss
// adds the filter search, which reads one memory row of sixteen filter entries per cycle over
// FILTER_DEPTH/16 rows, rounded up, in the scan and scan end states before evaluation. A finished
// result waits in the output register while the next item is accepted; while the receiver stalls
// a waiting result, the next finished result is held in the done state.
module eaf_lru_replacement import eaf_pkg::*; #(
  parameter int FILTER_DEPTH = 512
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [SET_W-1:0]  set_index,
  input  logic [WAY_W-1:0]  way_index,
  input  logic              was_hit,
  input  logic [ADDR_W-1:0] block_address,
  input  logic [ADDR_W-1:0] victim_address,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WAY_W-1:0]  victim_way,
  output logic              filter_match,
  output logic              promoted
);

  eaf_cmd_t          cmd;
  eaf_status_t       status;
  logic              cfg_wr;
  logic [LFSR_W-1:0] seed;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_RANDOM_SEED[2]);
  assign prdata = (paddr[2] == REG_RANDOM_SEED[2]) ? {16'd0, seed} : 32'd0;

  eaf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  eaf_datapath #(
    .FILTER_DEPTH (FILTER_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_wr         (cfg_wr),
    .cfg_data       (pwdata[LFSR_W-1:0]),
    .seed           (seed),
    .mode           (mode),
    .set_index      (set_index),
    .way_index      (way_index),
    .was_hit        (was_hit),
    .block_address  (block_address),
    .victim_address (victim_address),
    .victim_way     (victim_way),
    .filter_match   (filter_match),
    .promoted       (promoted)
  );

endmodule

### sim/tb_eaf_lru_replacement.sv
// Testbench for the evicted address filter replacement engine: it drives
// queries, hits and miss fills with a mirror of the ranks, filter and LFSR.
// Depends on eaf_pkg and eaf_lru_replacement.
`timescale 1ns / 1ps

module tb_eaf_lru_replacement;
  import eaf_pkg::*;

  localparam int DEPTH = 512;
  localparam int CYCLE_LIMIT = 400000;
  localparam bit QUERY = 1'b0;
  localparam bit UPDATE = 1'b1;
  localparam logic [2:0] SEED_ADDR = 3'(REG_RANDOM_SEED << 2);

  typedef struct packed {
    logic              mode;
    logic [SET_W-1:0]  set_index;
    logic [WAY_W-1:0]  way_index;
    logic              was_hit;
    logic [ADDR_W-1:0] block_address;
    logic [ADDR_W-1:0] victim_address;
  } access_t;

  typedef struct packed {
    logic [WAY_W-1:0] victim_way;
    logic             filter_match;
    logic             promoted;
  } decision_t;

  class replacement_board;
    logic [RANK_W-1:0] ranks[SETS][WAYS];
    logic [ADDR_W-1:0] evicted[DEPTH];
    bit                evicted_ok[DEPTH];
    int                write_ptr;
    logic [LFSR_W-1:0] lfsr;
    decision_t         pending[$];
    int                errors;
    int                checked;

    function void clear(logic [LFSR_W-1:0] seed);
      foreach (ranks[s, w]) ranks[s][w] = RANK_W'(w);
      foreach (evicted_ok[i]) evicted_ok[i] = 0;
      write_ptr = 0;
      lfsr = seed;
      errors = 0;
      checked = 0;
    endfunction

    function void load_seed(logic [LFSR_W-1:0] seed);
      lfsr = (seed == 0) ? SEED_RESET : seed;
    endfunction

    function void note_access(access_t a);
      decision_t d;
      bit take, found;
      logic [RANK_W-1:0] old;
      int best;
      d = '0;
      if (a.mode == QUERY) begin
        best = 0;
        for (int i = 1; i < WAYS; i++)
          if (ranks[a.set_index][i] > ranks[a.set_index][best]) best = i;
        d.victim_way = WAY_W'(best);
      end else begin
        take = 1;
        if (!a.was_hit) begin
          evicted[write_ptr] = a.victim_address;
          evicted_ok[write_ptr] = 1;
          write_ptr = (write_ptr + 1) % DEPTH;
          found = 0;
          for (int i = 0; i < DEPTH; i++)
            if (evicted_ok[i] && evicted[i] == a.block_address) found = 1;
          d.filter_match = found;
          if (!found) begin
            lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
            take = (lfsr[1:0] == 2'b00);
          end
        end
        if (take) begin
          old = ranks[a.set_index][a.way_index];
          for (int i = 0; i < WAYS; i++)
            if (ranks[a.set_index][i] < old) ranks[a.set_index][i]++;
          ranks[a.set_index][a.way_index] = 0;
          d.promoted = 1;
        end
      end
      pending.push_back(d);
    endfunction

    function void check_decision(decision_t got);
      decision_t exp;
      if (pending.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.victim_way !== exp.victim_way) begin
        $error("victim_way: expected %0d, got %0d", exp.victim_way, got.victim_way);
        errors++;
      end
      if (got.filter_match !== exp.filter_match) begin
        $error("filter_match: expected %0d, got %0d", exp.filter_match, got.filter_match);
        errors++;
      end
      if (got.promoted !== exp.promoted) begin
        $error("promoted: expected %0d, got %0d", exp.promoted, got.promoted);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  access_t item = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [WAY_W-1:0] victim_way;
  logic filter_match, promoted;

  replacement_board board;
  int sender_idle, receiver_idle, hold_left, cycles, readback_errors;
  logic [ADDR_W-1:0] recent_victims[$];

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  eaf_lru_replacement DUT (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall,
    .mode(item.mode), .set_index(item.set_index), .way_index(item.way_index),
    .was_hit(item.was_hit), .block_address(item.block_address),
    .victim_address(item.victim_address),
    .out_valid, .out_stall, .victim_way, .filter_match, .promoted
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && in_valid && !in_stall) board.note_access(item);

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_decision('{victim_way, filter_match, promoted});
    if (hold_left > 0) begin
      out_stall <= 1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle);
    end
  end

  task automatic write_seed(logic [31:0] value);
    logic [LFSR_W-1:0] stored;
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= SEED_ADDR; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    board.load_seed(value[15:0]);
    psel <= 1; pwrite <= 0; penable <= 0;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    stored = (value[15:0] == 0) ? SEED_RESET : value[15:0];
    if (prdata[15:0] !== stored) begin
      $error("random_seed: expected %0d, got %0d", stored, prdata[15:0]);
      readback_errors++;
    end
    psel <= 0; penable <= 0;
  endtask

  task automatic send(access_t a);
    if ($urandom_range(99) < sender_idle) begin
      in_valid <= 0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1;
    item <= a;
    if (a.mode == UPDATE && !a.was_hit) begin
      recent_victims.push_back(a.victim_address);
      if (recent_victims.size() > 48) void'(recent_victims.pop_front());
    end
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [ADDR_W-1:0] any_address();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return ADDR_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic access_t random_access();
    access_t a;
    a.mode = ($urandom_range(99) < 35) ? QUERY : UPDATE;
    a.set_index = ($urandom_range(99) < 75) ? SET_W'($urandom_range(5)) : SET_W'($urandom);
    a.way_index = WAY_W'($urandom);
    a.was_hit = 1'($urandom_range(1));
    a.victim_address = ($urandom_range(3) == 0 && recent_victims.size() > 0)
      ? recent_victims[$urandom_range(recent_victims.size() - 1)] : any_address();
    a.block_address = ($urandom_range(99) < 45 && recent_victims.size() > 0)
      ? recent_victims[$urandom_range(recent_victims.size() - 1)] : any_address();
    return a;
  endfunction

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    access_t d;
    logic [31:0] seeds[3];
    board = new();
    board.clear(SEED_RESET);
    sender_idle = 0;
    receiver_idle = 0;
    hold_left = 0;
    repeat (7) @(posedge clk);
    rst <= 0;

    // Directed items: reset ranks, extreme sets, ways and addresses.
    d = '{QUERY, 10'd0, 4'd0, 1'b0, '0, '0};            send(d);
    d = '{QUERY, 10'd1023, 4'd15, 1'b1, '1, '1};        send(d);
    d = '{UPDATE, 10'd0, 4'd15, 1'b1, '1, '0};          send(d);
    d = '{QUERY, 10'd0, 4'd0, 1'b0, '0, '0};            send(d);
    d = '{UPDATE, 10'd1023, 4'd0, 1'b1, '0, '1};        send(d);
    d = '{UPDATE, 10'd0, 4'd14, 1'b0, '1, '1};          send(d);
    d = '{UPDATE, 10'd0, 4'd3, 1'b0, '0, 58'h2AAAAAAAAAAAAAA}; send(d);
    d = '{UPDATE, 10'd0, 4'd3, 1'b0, 58'h155555555555555, '0}; send(d);
    d = '{UPDATE, 10'd0, 4'd7, 1'b0, 58'h2AAAAAAAAAAAAAA, '0}; send(d);
    for (int i = 0; i < 6; i++) begin
      d = '{UPDATE, 10'd2, 4'(i), 1'b0, 58'(i + 1000), 58'(i)}; send(d);
    end
    d = '{QUERY, 10'd0, 4'd0, 1'b0, '0, '0};            send(d);
    d = '{QUERY, 10'd2, 4'd0, 1'b0, '0, '0};            send(d);
    drain();

    seeds = '{32'h0000_FFFF, 32'h0000_0001, 32'h0000_0000};
    for (int phase = 0; phase < 3; phase++) begin
      write_seed(seeds[phase]);
      sender_idle = (phase == 0) ? 21 : (phase == 1) ? 55 : 0;
      receiver_idle = (phase == 0) ? 55 : (phase == 1) ? 21 : 0;
      if (phase == 2) hold_left = 300;
      for (int n = 0; n < 130; n++) send(random_access());
      drain();
    end
    write_seed({16'h0, 16'($urandom_range(65535, 1))});
    for (int n = 0; n < 30; n++) send(random_access());
    drain();

    $display("Checked %0d results over four seeds, with idling on both sides", board.checked);
    $display("and a long output hold-off, mixing queries, hits and filter misses.");
    if (board.errors == 0 && readback_errors == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
